/* hdl/cda_pkg.sv */
// Package for the calendar date arithmetic core: field widths, request codes,
// controller states, command and status bundles and the month tables.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package cda_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned MDAY_W   = 5;
  localparam int unsigned OFFSET_W = 21;
  localparam int unsigned SPAN_W   = 22;
  // Day numbers count from January 1 of year 0 and may go negative.
  localparam int unsigned DN_W     = 24;
  // Days before January 1 of a year up to 16383 fit in this width.
  localparam int unsigned BASE_W   = 23;
  localparam int unsigned REM_W    = 9;

  localparam logic [YEAR_W-1:0]    MAX_YEAR = 14'd9999;
  // Day number of 0001-01-01 and of 10000-01-01.
  localparam logic signed [DN_W-1:0] DN_FIRST = 24'sd366;
  localparam logic signed [DN_W-1:0] DN_END   = 24'sd3652425;
  localparam logic [SPAN_W-1:0]    SPAN_MAX = 22'h3FFFFF;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_SUB  = 2'd1,
    REQ_DIFF = 2'd2,
    REQ_CMP  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DAYNUM,
    ST_OFFSET,
    ST_FIND,
    ST_MONTH,
    ST_DIFF,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic walk_clr;
    logic walk_step;
    logic use_b;
    logic dn_store;
    logic offset;
    logic month_init;
    logic month_step;
    logic diff_calc;
    logic out_write;
  } cmd_t;

  typedef struct packed {
    req_type_e op;
    logic      at_target;
    logic      oor;
    logic      find_stop;
    logic      month_stop;
  } status_t;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic [YEAR_W-1:0]          in_year;
    logic [MONTH_W-1:0]         in_month;
    logic [MDAY_W-1:0]          in_mday;
    logic signed [OFFSET_W-1:0] day_offset;
    logic [YEAR_W-1:0]          ref_year;
    logic [MONTH_W-1:0]         ref_month;
    logic [MDAY_W-1:0]          ref_mday;
  } req_payload_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [MDAY_W-1:0]  out_mday;
    logic [SPAN_W-1:0]  span_days;
    logic               less_than;
    logic               equal_to;
    logic               out_of_range;
  } rsp_payload_t;

  // Length of month m (1 to 12) in a year with the given leap flag.
  function automatic logic [MDAY_W-1:0] month_days(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
    logic [MDAY_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before month m. Month 0 counts as January and any
  // month above 12 as December.
  function automatic logic [REM_W-1:0] cum_days(input logic leap,
                                                input logic [MONTH_W-1:0] m);
    logic [REM_W-1:0] days;
    case (m)
      4'd0, 4'd1: days = 9'd0;
      4'd2:       days = 9'd31;
      4'd3:       days = 9'd59;
      4'd4:       days = 9'd90;
      4'd5:       days = 9'd120;
      4'd6:       days = 9'd151;
      4'd7:       days = 9'd181;
      4'd8:       days = 9'd212;
      4'd9:       days = 9'd243;
      4'd10:      days = 9'd273;
      4'd11:      days = 9'd304;
      default:    days = 9'd334;
    endcase
    if (leap && (m > 4'd2)) begin
      days = days + 9'd1;
    end
    return days;
  endfunction

endpackage

/* hdl/cda_channels.sv */
// Handshake channels of the calendar date arithmetic core: the request
// channel and the result channel, each with valid, ready and payload.
// Depends on cda_pkg for the field widths.
`timescale 1ns / 1ps

interface cda_req_if;
  import cda_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [YEAR_W-1:0]          in_year;
  logic [MONTH_W-1:0]         in_month;
  logic [MDAY_W-1:0]          in_mday;
  logic signed [OFFSET_W-1:0] day_offset;
  logic [YEAR_W-1:0]          ref_year;
  logic [MONTH_W-1:0]         ref_month;
  logic [MDAY_W-1:0]          ref_mday;

  modport source (
    output valid, req_type, in_year, in_month, in_mday, day_offset,
           ref_year, ref_month, ref_mday,
    input  ready
  );

  modport sink (
    input  valid, req_type, in_year, in_month, in_mday, day_offset,
           ref_year, ref_month, ref_mday,
    output ready
  );
endinterface

interface cda_rsp_if;
  import cda_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [MDAY_W-1:0]  out_mday;
  logic [SPAN_W-1:0]  span_days;
  logic               less_than;
  logic               equal_to;
  logic               out_of_range;

  modport source (
    output valid, out_year, out_month, out_mday, span_days, less_than,
           equal_to, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, out_year, out_month, out_mday, span_days, less_than,
           equal_to, out_of_range,
    output ready
  );
endinterface

/* hdl/calendar_date_arithmetic_core.sv */
// Top level of the calendar date arithmetic core: Gregorian add, subtract,
// day difference and compare on one request channel and one result channel.
// Depends on cda_pkg, cda_channels, cda_ctrl and cda_datapath.
//
// Usage: a request item on req_i carries the operation code, the primary
// date, a signed day offset and a second date. Each request gives exactly
// one result item on rsp_o. Both channels move an item on a rising clock
// edge at which valid and ready are both high.
// Operation: the date is turned into a day number by walking one year per
// clock from year 0, and an add or subtract result is turned back into a
// date the same way, then one month per clock. A compare needs no walk; a
// difference walks both of its dates, the primary one first.
// Throughput: one request at a time; req_i.ready is high only while the
// core is idle. A finished result waits in the output register while the
// receiver stalls; the core then takes the next request and stalls only at
// the point of writing its result until the register is free.
// Reset is asynchronous and active low; it empties the core, drops the
// result valid and leaves the core ready at once.
`timescale 1ns / 1ps

module calendar_date_arithmetic_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  cda_req_if.sink  req_i,
  cda_rsp_if.source rsp_o
);
  import cda_pkg::*;

  req_payload_t req_payload;
  rsp_payload_t rsp_payload;
  cmd_t         cmd;
  status_t      status;
  logic         req_ready;
  logic         rsp_valid;

  // Gather the request fields into one bundle for the datapath.
  assign req_payload.req_type   = req_i.req_type;
  assign req_payload.in_year    = req_i.in_year;
  assign req_payload.in_month   = req_i.in_month;
  assign req_payload.in_mday    = req_i.in_mday;
  assign req_payload.day_offset = req_i.day_offset;
  assign req_payload.ref_year   = req_i.ref_year;
  assign req_payload.ref_month  = req_i.ref_month;
  assign req_payload.ref_mday   = req_i.ref_mday;

  // The controller sequences the walks and owns both handshakes.
  cda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the request, the walkers and the result register.
  cda_datapath u_datapath (
    .clk_i    (clk_i),
    .req_i    (req_payload),
    .cmd_i    (cmd),
    .status_o (status),
    .rsp_o    (rsp_payload)
  );

  assign req_i.ready = req_ready;

  // The result register drives the result channel directly.
  assign rsp_o.valid        = rsp_valid;
  assign rsp_o.out_year     = rsp_payload.out_year;
  assign rsp_o.out_month    = rsp_payload.out_month;
  assign rsp_o.out_mday     = rsp_payload.out_mday;
  assign rsp_o.span_days    = rsp_payload.span_days;
  assign rsp_o.less_than    = rsp_payload.less_than;
  assign rsp_o.equal_to     = rsp_payload.equal_to;
  assign rsp_o.out_of_range = rsp_payload.out_of_range;

endmodule

/* hdl/cda_ctrl.sv */
// Sequencer of the calendar date arithmetic core: walks the year and month
// loops of the datapath and owns both handshakes.
// Depends on cda_pkg.
`timescale 1ns / 1ps

module cda_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic [1:0]         req_type_i,
  output logic               req_ready_o,
  input  logic               rsp_ready_i,
  output logic               rsp_valid_o,
  input  cda_pkg::status_t   status_i,
  output cda_pkg::cmd_t      cmd_o
);
  import cda_pkg::*;

  state_e state_q, state_d;
  logic   pass_b_q, pass_b_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   accept;
  logic   out_free;
  cmd_t   cmd;

  assign accept   = req_valid_i && (state_q == ST_IDLE);
  assign out_free = !rsp_valid_q || rsp_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = (req_type_i == REQ_CMP) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.at_target) begin
          state_d = ST_DAYNUM;
        end
      end
      ST_DAYNUM: begin
        if (pass_b_q) begin
          state_d = ST_DIFF;
        end else if (status_i.op == REQ_DIFF) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_OFFSET;
        end
      end
      ST_OFFSET: state_d = ST_FIND;
      ST_FIND: begin
        if (status_i.oor) begin
          state_d = ST_DONE;
        end else if (status_i.find_stop) begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (status_i.month_stop) begin
          state_d = ST_DONE;
        end
      end
      ST_DIFF: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd       = '0;
    cmd.use_b = pass_b_q;
    case (state_q)
      ST_IDLE: begin
        cmd.load     = accept;
        cmd.walk_clr = accept;
      end
      ST_WALK: begin
        cmd.walk_step = !status_i.at_target;
      end
      ST_DAYNUM: begin
        cmd.dn_store = 1'b1;
        cmd.walk_clr = !pass_b_q && (status_i.op == REQ_DIFF);
      end
      ST_OFFSET: begin
        cmd.offset   = 1'b1;
        cmd.walk_clr = 1'b1;
      end
      ST_FIND: begin
        cmd.month_init = !status_i.oor && status_i.find_stop;
        cmd.walk_step  = !status_i.oor && !status_i.find_stop;
      end
      ST_MONTH: begin
        cmd.month_step = !status_i.month_stop;
      end
      ST_DIFF: begin
        cmd.diff_calc = 1'b1;
      end
      ST_DONE: begin
        cmd.out_write = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    pass_b_d = pass_b_q;
    if (cmd.load) begin
      pass_b_d = 1'b0;
    end else if (cmd.dn_store && cmd.walk_clr) begin
      pass_b_d = 1'b1;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd.out_write) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_b_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_b_q    <= pass_b_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign cmd_o       = cmd;

endmodule

/* hdl/cda_datapath.sv */
// Datapath of the calendar date arithmetic core: request registers, the
// year walker with its leap-year counters, the month walker and the result
// register. Depends on cda_pkg.
`timescale 1ns / 1ps

module cda_datapath (
  input  logic                  clk_i,
  input  cda_pkg::req_payload_t req_i,
  input  cda_pkg::cmd_t         cmd_i,
  output cda_pkg::status_t      status_o,
  output cda_pkg::rsp_payload_t rsp_o
);
  import cda_pkg::*;

  req_payload_t req_q;

  // Year walker: year, days before its January 1, and the year modulo
  // 4, 100 and 400.
  logic [YEAR_W-1:0] yy_q;
  logic [BASE_W-1:0] base_q;
  logic [1:0]        c4_q;
  logic [6:0]        c100_q;
  logic [8:0]        c400_q;

  logic [DN_W-1:0]   dn_a_q, dn_b_q, dn_res_q;
  logic              oor_q;
  logic [REM_W-1:0]  rem_q;
  logic [MONTH_W-1:0] mm_q;
  logic [BASE_W-1:0] diff_q;
  rsp_payload_t      rsp_q, rsp_d;

  logic               leap;
  logic [REM_W-1:0]   ylen;
  logic [YEAR_W-1:0]  target;
  logic [MONTH_W-1:0] sel_month;
  logic [MDAY_W-1:0]  sel_mday;
  logic [DN_W-1:0]    dn_new;
  logic [DN_W-1:0]    off_ext;
  logic [DN_W-1:0]    off_eff;
  logic [DN_W-1:0]    dn_sum;
  logic [DN_W-1:0]    next_end;
  logic [MDAY_W-1:0]  mlen;
  logic [DN_W-1:0]    delta;
  logic               less;
  req_type_e          op;

  assign op   = req_type_e'(req_q.req_type);
  assign leap = (c4_q == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));
  assign ylen = leap ? 9'd366 : 9'd365;

  assign target    = cmd_i.use_b ? req_q.ref_year  : req_q.in_year;
  assign sel_month = cmd_i.use_b ? req_q.ref_month : req_q.in_month;
  assign sel_mday  = cmd_i.use_b ? req_q.ref_mday  : req_q.in_mday;

  // Day number of the selected date once the walker stands at its year.
  assign dn_new = {1'b0, base_q} + DN_W'(cum_days(leap, sel_month))
                + DN_W'(sel_mday) - DN_W'(1);

  assign off_ext = {{(DN_W - OFFSET_W){req_q.day_offset[OFFSET_W-1]}}, req_q.day_offset};
  assign off_eff = (op == REQ_SUB) ? (DN_W'(0) - off_ext) : off_ext;
  assign dn_sum  = dn_a_q + off_eff;

  assign next_end = {1'b0, base_q} + DN_W'(ylen);
  assign mlen     = month_days(leap, mm_q);
  assign delta    = dn_a_q - dn_b_q;

  always_comb begin
    if (req_q.in_year != req_q.ref_year) begin
      less = req_q.in_year < req_q.ref_year;
    end else if (req_q.in_month != req_q.ref_month) begin
      less = req_q.in_month < req_q.ref_month;
    end else begin
      less = req_q.in_mday < req_q.ref_mday;
    end
  end

  // Result of the finished request; fields that the operation does not use
  // stay zero.
  always_comb begin
    rsp_d = '0;
    case (op)
      REQ_ADD, REQ_SUB: begin
        if (oor_q) begin
          rsp_d.out_year     = req_q.in_year;
          rsp_d.out_month    = req_q.in_month;
          rsp_d.out_mday     = req_q.in_mday;
          rsp_d.out_of_range = 1'b1;
        end else begin
          rsp_d.out_year  = yy_q;
          rsp_d.out_month = mm_q;
          rsp_d.out_mday  = MDAY_W'(rem_q) + MDAY_W'(1);
        end
      end
      REQ_DIFF: begin
        rsp_d.span_days = diff_q[BASE_W-1] ? SPAN_MAX : diff_q[SPAN_W-1:0];
      end
      REQ_CMP: begin
        rsp_d.less_than = less;
        rsp_d.equal_to  = (req_q.in_year == req_q.ref_year)
                       && (req_q.in_month == req_q.ref_month)
                       && (req_q.in_mday == req_q.ref_mday);
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end

    if (cmd_i.walk_clr) begin
      yy_q   <= '0;
      base_q <= '0;
      c4_q   <= '0;
      c100_q <= '0;
      c400_q <= '0;
    end else if (cmd_i.walk_step) begin
      yy_q   <= yy_q + YEAR_W'(1);
      base_q <= base_q + BASE_W'(ylen);
      c4_q   <= c4_q + 2'd1;
      c100_q <= (c100_q == 7'd99)  ? 7'd0 : c100_q + 7'd1;
      c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
    end

    if (cmd_i.dn_store) begin
      if (cmd_i.use_b) begin
        dn_b_q <= dn_new;
      end else begin
        dn_a_q <= dn_new;
      end
    end

    if (cmd_i.offset) begin
      dn_res_q <= dn_sum;
      oor_q    <= ($signed(dn_sum) < DN_FIRST) || ($signed(dn_sum) >= DN_END);
    end

    // The day within the found year is below 366, so the low bits suffice.
    if (cmd_i.month_init) begin
      rem_q <= dn_res_q[REM_W-1:0] - base_q[REM_W-1:0];
      mm_q  <= MONTH_W'(1);
    end else if (cmd_i.month_step) begin
      rem_q <= rem_q - REM_W'(mlen);
      mm_q  <= mm_q + MONTH_W'(1);
    end

    if (cmd_i.diff_calc) begin
      diff_q <= delta[DN_W-1] ? BASE_W'(DN_W'(0) - delta) : delta[BASE_W-1:0];
    end

    if (cmd_i.out_write) begin
      rsp_q <= rsp_d;
    end
  end

  assign status_o.op         = op;
  assign status_o.at_target  = (yy_q == target);
  assign status_o.oor        = oor_q;
  assign status_o.find_stop  = (yy_q == MAX_YEAR) || (next_end > dn_res_q);
  assign status_o.month_stop = (mm_q == MONTH_W'(12)) || (rem_q < REM_W'(mlen));
  assign rsp_o               = rsp_q;

endmodule

/* dv/calendar_date_arithmetic_core_tb.sv */
// Self-checking testbench for the calendar date arithmetic core: directed and
// random add, subtract, day difference and compare items with random stalls.
// Depends on cda_pkg, cda_channels and the calendar_date_arithmetic_core RTL.
`timescale 1ns / 1ps

module calendar_date_arithmetic_core_tb;
  import cda_pkg::*;

  // The slowest legal item is a difference between two years near 16383.
  // Even if every item of the run were that slow, with stalls on both sides
  // added, the run would stay under about 60 ms. The watchdog below allows
  // more than three times that.
  localparam longint WATCHDOG_NS = 200_000_000;
  localparam int     RANDOM_ITEMS = 74;
  localparam int     STALL_PCT = 34;
  localparam int     SETTLE_CYCLES = 200;

  logic clk;
  logic rst_n;

  // Both sides stop idling while this is set.
  bit calm;
  int mismatch_cnt;

  // Results still owed by the core, oldest first.
  rsp_payload_t awaited_rsp_q[$];

  cda_req_if req_if ();
  cda_rsp_if rsp_if ();

  calendar_date_arithmetic_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor. Day numbers count from January 1 of year 0, which is
  // a leap year under the proleptic Gregorian calendar.
  // ---------------------------------------------------------------------------

  function automatic bit leap_year(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_length(longint y, int m);
    case (m)
      2:             return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic longint days_to_jan1(longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  // A month of 0 counts as January and one above 12 as December. The day is
  // simply counted from the first of the month, so day 0 and days past the
  // end of the month spill into the neighboring months.
  function automatic longint ordinal_day(int y, int m, int d);
    longint n;
    int     mm;
    mm = (m < 1) ? 1 : ((m > 12) ? 12 : m);
    n = days_to_jan1(y);
    for (int k = 1; k < mm; k++) begin
      n += month_length(y, k);
    end
    return n + d - 1;
  endfunction

  // Only called with a day number inside years 1 to 9999.
  function automatic void ordinal_to_date(longint dn, output int y, output int m,
                                          output int d);
    longint yy;
    longint rem;
    yy = dn * 400 / 146097;
    if (yy > 9999) begin
      yy = 9999;
    end
    if (yy < 0) begin
      yy = 0;
    end
    while (yy < 9999 && days_to_jan1(yy + 1) <= dn) begin
      yy++;
    end
    while (yy > 0 && days_to_jan1(yy) > dn) begin
      yy--;
    end
    rem = dn - days_to_jan1(yy);
    m = 1;
    while (m < 12 && rem >= month_length(yy, m)) begin
      rem -= month_length(yy, m);
      m++;
    end
    y = int'(yy);
    d = int'(rem) + 1;
  endfunction

  function automatic rsp_payload_t compute_date_result(req_payload_t r);
    rsp_payload_t res;
    longint       off;
    longint       dn;
    longint       span;
    int           y;
    int           m;
    int           d;
    res = '0;
    case (req_type_e'(r.req_type))
      REQ_ADD, REQ_SUB: begin
        off = longint'($signed(r.day_offset));
        if (req_type_e'(r.req_type) == REQ_SUB) begin
          off = -off;
        end
        dn = ordinal_day(int'(r.in_year), int'(r.in_month), int'(r.in_mday)) + off;
        if (dn < days_to_jan1(1) || dn >= days_to_jan1(10000)) begin
          // Out of range: the primary date comes back exactly as given.
          res.out_year     = r.in_year;
          res.out_month    = r.in_month;
          res.out_mday     = r.in_mday;
          res.out_of_range = 1'b1;
        end else begin
          ordinal_to_date(dn, y, m, d);
          res.out_year  = y[YEAR_W-1:0];
          res.out_month = m[MONTH_W-1:0];
          res.out_mday  = d[MDAY_W-1:0];
        end
      end
      REQ_DIFF: begin
        span = ordinal_day(int'(r.in_year), int'(r.in_month), int'(r.in_mday))
             - ordinal_day(int'(r.ref_year), int'(r.ref_month), int'(r.ref_mday));
        if (span < 0) begin
          span = -span;
        end
        if (span > longint'(SPAN_MAX)) begin
          span = longint'(SPAN_MAX);
        end
        res.span_days = span[SPAN_W-1:0];
      end
      default: begin
        // Compare works on the raw fields, with no normalization at all.
        if (r.in_year != r.ref_year) begin
          res.less_than = r.in_year < r.ref_year;
        end else if (r.in_month != r.ref_month) begin
          res.less_than = r.in_month < r.ref_month;
        end else begin
          res.less_than = r.in_mday < r.ref_mday;
        end
        res.equal_to = (r.in_year == r.ref_year) && (r.in_month == r.ref_month)
                    && (r.in_mday == r.ref_mday);
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Inputs change at the falling edge; an item counts as taken
  // at the rising edge where valid and ready are both high, and its expected
  // result is queued at that edge.
  // ---------------------------------------------------------------------------

  task automatic send_item(req_payload_t r);
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid      <= 1'b1;
    req_if.req_type   <= r.req_type;
    req_if.in_year    <= r.in_year;
    req_if.in_month   <= r.in_month;
    req_if.in_mday    <= r.in_mday;
    req_if.day_offset <= r.day_offset;
    req_if.ref_year   <= r.ref_year;
    req_if.ref_month  <= r.ref_month;
    req_if.ref_mday   <= r.ref_mday;
    do begin
      @(posedge clk);
    end while (!req_if.ready);
    awaited_rsp_q.push_back(compute_date_result(r));
  endtask

  task automatic issue(req_type_e op, int y, int m, int d, int off,
                       int ry = 1, int rm = 1, int rd = 1);
    req_payload_t r;
    r.req_type   = op;
    r.in_year    = y[YEAR_W-1:0];
    r.in_month   = m[MONTH_W-1:0];
    r.in_mday    = d[MDAY_W-1:0];
    r.day_offset = off[OFFSET_W-1:0];
    r.ref_year   = ry[YEAR_W-1:0];
    r.ref_month  = rm[MONTH_W-1:0];
    r.ref_mday   = rd[MDAY_W-1:0];
    send_item(r);
  endtask

  // Holds the request side quiet until every owed result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (awaited_rsp_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready is redrawn at every falling edge, and each result is
  // checked against the oldest expectation at the rising edge that takes it.
  // ---------------------------------------------------------------------------

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready <= calm || ($urandom_range(99) >= STALL_PCT);
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    rsp_payload_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (awaited_rsp_q.size() == 0) begin
        $error("result item arrived with no request outstanding");
        mismatch_cnt++;
      end else begin
        want = awaited_rsp_q.pop_front();
        check_field("out_year", longint'(want.out_year), longint'(rsp_if.out_year));
        check_field("out_month", longint'(want.out_month), longint'(rsp_if.out_month));
        check_field("out_mday", longint'(want.out_mday), longint'(rsp_if.out_mday));
        check_field("span_days", longint'(want.span_days), longint'(rsp_if.span_days));
        check_field("less_than", longint'(want.less_than), longint'(rsp_if.less_than));
        check_field("equal_to", longint'(want.equal_to), longint'(rsp_if.equal_to));
        check_field("out_of_range", longint'(want.out_of_range),
                    longint'(rsp_if.out_of_range));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests. Years are kept moderate where possible, since the core
  // walks one year per clock in each direction.
  // ---------------------------------------------------------------------------

  // Day steps across the leap-year rule, month and year wraps, and the
  // largest offsets in both directions.
  task automatic test_add_sub_steps();
    issue(REQ_ADD, 2024, 2, 28, 1);          // leap year by four
    issue(REQ_ADD, 1900, 2, 28, 1);          // century that is not leap
    issue(REQ_SUB, 2000, 3, 1, 1);           // century that is leap
    issue(REQ_ADD, 1999, 12, 31, 1);         // December into next January
    issue(REQ_SUB, 1, 1, 1, -1);             // negative offset reverses a subtract
    issue(REQ_ADD, 1, 1, 1, 1048575);        // largest positive offset
    issue(REQ_ADD, 9999, 12, 31, -1048576);  // most negative offset
    issue(REQ_SUB, 5000, 6, 15, -1048576);   // negating the most negative offset
  endtask

  // Results that would leave years 1 to 9999 return the input date flagged.
  task automatic test_range_limits();
    issue(REQ_SUB, 1, 1, 1, 1);
    issue(REQ_ADD, 9999, 12, 31, 1);
    issue(REQ_ADD, 9000, 1, 1, 1048575);
    issue(REQ_ADD, 0, 6, 1, 0);              // year 0 lies before the first date
  endtask

  task automatic test_day_span();
    issue(REQ_DIFF, 2024, 3, 1, 0, 2024, 2, 1);     // first date later
    issue(REQ_DIFF, 1, 1, 1, 0, 9999, 12, 31);      // whole legal calendar
    issue(REQ_DIFF, 16383, 15, 31, 0, 0, 0, 0);     // saturates
    issue(REQ_DIFF, 777, 7, 7, 0, 777, 7, 7);       // same day
  endtask

  task automatic test_date_order();
    issue(REQ_CMP, 12, 5, 9, 0, 12, 5, 9);
    issue(REQ_CMP, 11, 12, 31, 0, 12, 1, 1);
    issue(REQ_CMP, 12, 4, 30, 0, 12, 5, 1);
    issue(REQ_CMP, 12, 5, 8, 0, 12, 5, 9);
    issue(REQ_CMP, 13, 0, 0, 0, 12, 15, 31);       // raw fields, later date
  endtask

  // Months outside 1 to 12, day 0, days past a month's end, year 0 and a
  // year above 9999 on input.
  task automatic test_malformed_dates();
    issue(REQ_ADD, 2023, 0, 0, 0);
    issue(REQ_ADD, 2023, 15, 31, 0);
    issue(REQ_SUB, 2023, 4, 31, 0);
    issue(REQ_ADD, 0, 12, 31, 1);
    issue(REQ_ADD, 12000, 1, 1, -1048576);
  endtask

  // ---------------------------------------------------------------------------
  // Random mix. Most years are small to keep the walk short; a few cover the
  // full legal range and the full width of the field.
  // ---------------------------------------------------------------------------

  function automatic int pick_year();
    int p;
    p = $urandom_range(99);
    if (p < 85) begin
      return $urandom_range(400, 1);
    end else if (p < 95) begin
      return $urandom_range(9999, 1);
    end
    return $urandom_range(16383, 0);
  endfunction

  function automatic int pick_month();
    return ($urandom_range(99) < 90) ? $urandom_range(12, 1) : $urandom_range(15, 0);
  endfunction

  function automatic int pick_mday(int y, int m);
    if ($urandom_range(99) < 90 && m >= 1 && m <= 12) begin
      return $urandom_range(month_length(y, m), 1);
    end
    return $urandom_range(31, 0);
  endfunction

  function automatic int pick_offset();
    logic [OFFSET_W-1:0] raw;
    int                  p;
    p = $urandom_range(99);
    if (p < 50) begin
      return int'($urandom_range(4000)) - 2000;
    end else if (p < 80) begin
      return int'($urandom_range(400000)) - 200000;
    end
    raw = OFFSET_W'($urandom());
    return int'($signed(raw));
  endfunction

  task automatic test_random_mix();
    int y;
    int m;
    int d;
    int ry;
    int rm;
    int rd;
    int p;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // A stretch in the middle runs with neither side idling.
      calm = (i >= 40 && i < 60);
      y = pick_year();
      m = pick_month();
      d = pick_mday(y, m);
      p = $urandom_range(99);
      if (p < 15) begin
        ry = y;
        rm = m;
        rd = d;
      end else if (p < 55) begin
        // Near the primary date, so month and day decide the order.
        ry = y;
        rm = ($urandom_range(1) == 1) ? m : pick_month();
        rd = (d + int'($urandom_range(4)) - 2) & 31;
      end else begin
        ry = pick_year();
        rm = pick_month();
        rd = pick_mday(ry, rm);
      end
      issue(req_type_e'($urandom_range(3)), y, m, d, pick_offset(), ry, rm, rd);
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, directed tests with a full drain after them, then
  // the random mix, a final drain and a short settle for stray results.
  // ---------------------------------------------------------------------------

  initial begin
    rst_n             = 1'b0;
    calm              = 1'b0;
    mismatch_cnt      = 0;
    req_if.valid      = 1'b0;
    req_if.req_type   = '0;
    req_if.in_year    = '0;
    req_if.in_month   = '0;
    req_if.in_mday    = '0;
    req_if.day_offset = '0;
    req_if.ref_year   = '0;
    req_if.ref_month  = '0;
    req_if.ref_mday   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_add_sub_steps();
    test_range_limits();
    test_day_span();
    test_date_order();
    test_malformed_dates();
    wait_for_results();
    test_random_mix();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* calendar_date_arithmetic_core.f */
hdl/cda_pkg.sv
hdl/cda_channels.sv
hdl/cda_ctrl.sv
hdl/cda_datapath.sv
hdl/calendar_date_arithmetic_core.sv
dv/calendar_date_arithmetic_core_tb.sv
